// ===== rtl/playfair_digraph_encrypt_assert.svh =====
// assertion macros for the playfair digraph encryption block
// expects signals named clock and reset in the including module
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH

// same-cycle implication
`define PF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("playfair assertion failed");

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("playfair assertion failed");

`endif

// ===== rtl/pf_pkg.sv =====
// shared types, constants and helpers for the playfair digraph encryption block
// no dependencies
package pf_pkg;

   localparam int SIDE     = 5;
   localparam int LETTER_W = 5;
   localparam int POS_W    = 3;
   localparam int IDX_W    = 3;
   localparam int SLOTS    = 4;
   localparam int COUNT_W  = 3;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [POS_W-1:0] pos_idx_type;
   typedef letter_type [SIDE-1:0] row_type;
   typedef row_type [SIDE-1:0] square_type;

   typedef struct packed {
      pos_idx_type row;
      pos_idx_type col;
   } pos_type;

   typedef struct packed {
      logic                       valid;
      logic [COUNT_W-1:0]         count;
      letter_type [SLOTS-1:0]     letters;
   } result_load_type;

   typedef enum logic [IDX_W-1:0] {
      REG_KEY_ROW_0 = 3'd0,
      REG_KEY_ROW_1 = 3'd1,
      REG_KEY_ROW_2 = 3'd2,
      REG_KEY_ROW_3 = 3'd3,
      REG_KEY_ROW_4 = 3'd4
   } reg_index_type;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_X = 5'd23;
   localparam letter_type LETTER_Z = 5'd25;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_PAIR = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_TWO_PAIRS = 3'd4;

   // alphabet without i, row-major
   localparam square_type KEY_RESET = {
      25'd27025109, 25'd21613104, 25'd16201099, 25'd10788037, 25'd4294688
   };

   function automatic pos_idx_type wrap_next(input pos_idx_type p);
      pos_idx_type r;
      if (p == pos_idx_type'(SIDE - 1)) begin
         r = '0;
      end else begin
         r = p + pos_idx_type'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/pf_locate.sv =====
// position search of one letter in the key square, parallel compare
// depends on pf_pkg
module pf_locate (
   input  pf_pkg::square_type square,
   input  pf_pkg::letter_type letter,
   output pf_pkg::pos_type    pos
);

   // scan backward so the first row-major match wins; absent letter sits at row 0, column 0
   always_comb begin
      pos = '0;
      for (int r = pf_pkg::SIDE - 1; r >= 0; r--) begin
         for (int c = pf_pkg::SIDE - 1; c >= 0; c--) begin
            if (square[r][c] == letter) begin
               pos.row = pf_pkg::pos_idx_type'(r);
               pos.col = pf_pkg::pos_idx_type'(c);
            end
         end
      end
   end

endmodule

// ===== rtl/pf_pair.sv =====
// playfair rules for one digraph: same row, same column, rectangle
// depends on pf_pkg
module pf_pair (
   input  pf_pkg::square_type square,
   input  pf_pkg::pos_type    pos_a,
   input  pf_pkg::pos_type    pos_b,
   output pf_pkg::letter_type cipher_a,
   output pf_pkg::letter_type cipher_b
);

   always_comb begin
      if (pos_a.row == pos_b.row) begin
         cipher_a = square[pos_a.row][pf_pkg::wrap_next(pos_a.col)];
         cipher_b = square[pos_b.row][pf_pkg::wrap_next(pos_b.col)];
      end else if (pos_a.col == pos_b.col) begin
         cipher_a = square[pf_pkg::wrap_next(pos_a.row)][pos_a.col];
         cipher_b = square[pf_pkg::wrap_next(pos_b.row)][pos_b.col];
      end else begin
         cipher_a = square[pos_a.row][pos_b.col];
         cipher_b = square[pos_b.row][pos_a.col];
      end
   end

endmodule

// ===== rtl/pf_rsp_buf.sv =====
// result register bank: holds the cipher letters of one item and hands them out in order
// depends on pf_pkg
module pf_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  pf_pkg::result_load_type load,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output pf_pkg::letter_type     rsp_cipher_letter,
   output logic                   rsp_last_of_run,
   output logic                   bank_free
);

   logic [pf_pkg::COUNT_W-1:0]           count_ff, count_in;
   pf_pkg::letter_type [pf_pkg::SLOTS-1:0] slot_ff, slot_in;
   logic                                  pop;

   always_comb begin
      pop       = (count_ff != pf_pkg::COUNT_NONE) && !rsp_stall;
      bank_free = (count_ff == pf_pkg::COUNT_NONE) ||
                  ((count_ff == pf_pkg::COUNT_ONE) && pop);
      count_in  = count_ff;
      slot_in   = slot_ff;
      if (load.valid) begin
         count_in = load.count;
         slot_in  = load.letters;
      end else if (pop) begin
         count_in = count_ff - pf_pkg::COUNT_ONE;
         for (int k = 0; k < pf_pkg::SLOTS - 1; k++) begin
            slot_in[k] = slot_ff[k + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= pf_pkg::COUNT_NONE;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_valid         = (count_ff != pf_pkg::COUNT_NONE);
   assign rsp_cipher_letter = slot_ff[0];
   assign rsp_last_of_run   = (count_ff == pf_pkg::COUNT_ONE);

endmodule

// ===== rtl/playfair_digraph_encrypt.sv =====
// top level of the playfair digraph encryption block
// depends on pf_pkg, pf_locate, pf_pair, pf_rsp_buf and playfair_digraph_encrypt_assert.svh
//
// Plaintext letters enter one per cycle, while req_stall is low, into an input register;
// the registered letters are paired into digraphs (i read as j, x inserted between doubled
// letters, x padding on end_of_message) and up to two digraphs at once are encrypted
// against the key square with a parallel compare. The cipher letters go to a four-entry
// result bank and leave one per cycle while rsp_stall is low, the last one of each item
// marked with last_of_run. An item with no result does not wait for the bank; an item
// with results holds the input until the bank is free. Key rows are written through the
// csr port while the block is idle, a rule for the user that the block does not enforce.
`include "playfair_digraph_encrypt_assert.svh"

module playfair_digraph_encrypt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [4:0]               req_letter,
   input  logic                     req_end_of_message,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [4:0]               rsp_cipher_letter,
   output logic                     rsp_last_of_run,
   input  logic                     csr_write_enable,
   input  logic [pf_pkg::IDX_W-1:0] csr_index,
   input  logic [24:0]              csr_write_data
);

   pf_pkg::square_type key_ff, key_in;

   logic               in_valid_ff, in_valid_in;
   pf_pkg::letter_type in_letter_ff, in_letter_in;
   logic               in_eom_ff, in_eom_in;

   logic               held_valid_ff, held_valid_in;
   pf_pkg::letter_type held_letter_ff, held_letter_in;

   pf_pkg::letter_type norm_letter;
   logic               accept, same, pair_a_on, pair_b_on, has_results, step_go, bank_free;

   pf_pkg::pos_type    pos_held, pos_cur, pos_x, pos_a_second;
   pf_pkg::letter_type a_first, a_second, b_first, b_second;
   pf_pkg::result_load_type load;

   // key square registers
   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pf_pkg::REG_KEY_ROW_0: key_in[0] = csr_write_data;
            pf_pkg::REG_KEY_ROW_1: key_in[1] = csr_write_data;
            pf_pkg::REG_KEY_ROW_2: key_in[2] = csr_write_data;
            pf_pkg::REG_KEY_ROW_3: key_in[3] = csr_write_data;
            pf_pkg::REG_KEY_ROW_4: key_in[4] = csr_write_data;
            default: key_in = key_ff;
         endcase
      end
   end

   // input normalization: out of range reads as z, i reads as j
   always_comb begin
      norm_letter = (req_letter > pf_pkg::LETTER_Z) ? pf_pkg::LETTER_Z : req_letter;
      if (norm_letter == pf_pkg::LETTER_I) begin
         norm_letter = pf_pkg::LETTER_J;
      end
   end

   // pairing control
   always_comb begin
      same        = held_valid_ff && (held_letter_ff == in_letter_ff);
      pair_a_on   = held_valid_ff;
      pair_b_on   = in_eom_ff && (!held_valid_ff || same);
      has_results = pair_a_on || pair_b_on;
      step_go     = in_valid_ff && (bank_free || !has_results);
      req_stall   = in_valid_ff && !step_go;
      accept      = req_valid && !req_stall;

      in_valid_in  = accept || (in_valid_ff && !step_go);
      in_letter_in = accept ? norm_letter : in_letter_ff;
      in_eom_in    = accept ? req_end_of_message : in_eom_ff;

      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      if (step_go) begin
         held_valid_in  = !in_eom_ff && (!held_valid_ff || same);
         held_letter_in = in_letter_ff;
      end
   end

   pf_locate u_locate_held (.square(key_ff), .letter(held_letter_ff), .pos(pos_held));
   pf_locate u_locate_cur  (.square(key_ff), .letter(in_letter_ff),   .pos(pos_cur));
   pf_locate u_locate_x    (.square(key_ff), .letter(pf_pkg::LETTER_X), .pos(pos_x));

   assign pos_a_second = same ? pos_x : pos_cur;

   pf_pair u_pair_a (
      .square  (key_ff),
      .pos_a   (pos_held),
      .pos_b   (pos_a_second),
      .cipher_a(a_first),
      .cipher_b(a_second)
   );

   // the padded pair always starts with the current letter
   pf_pair u_pair_b (
      .square  (key_ff),
      .pos_a   (pos_cur),
      .pos_b   (pos_x),
      .cipher_a(b_first),
      .cipher_b(b_second)
   );

   always_comb begin
      load.valid   = step_go && has_results;
      load.count   = pf_pkg::COUNT_PAIR;
      load.letters = {b_second, b_first, a_second, a_first};
      if (pair_a_on && pair_b_on) begin
         load.count = pf_pkg::COUNT_TWO_PAIRS;
      end else if (pair_b_on) begin
         load.letters = {b_second, b_first, b_second, b_first};
      end
   end

   pf_rsp_buf u_rsp_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_cipher_letter(rsp_cipher_letter),
      .rsp_last_of_run  (rsp_last_of_run),
      .bank_free        (bank_free)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= pf_pkg::KEY_RESET;
         in_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         held_letter_ff <= '0;
      end else begin
         key_ff         <= key_in;
         in_valid_ff    <= in_valid_in;
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
      end
   end

   always_ff @(posedge clock) begin
      in_letter_ff <= in_letter_in;
      in_eom_ff    <= in_eom_in;
   end

   `PF_ASSERT_NOW(a_load_when_free, load.valid, bank_free)
   `PF_ASSERT_NEXT(a_eom_clears_held, step_go && in_eom_ff, !held_valid_ff)
   `PF_ASSERT_NEXT(a_last_drains_bank,
      rsp_valid && rsp_last_of_run && !rsp_stall && !load.valid, !rsp_valid)

endmodule
